@@ sv/auto_range_pedal_normalizer_macros.svh @@
// Assertion macros used by the block's top-level RTL file.
`ifndef AUTO_RANGE_PEDAL_NORMALIZER_MACROS_SVH
`define AUTO_RANGE_PEDAL_NORMALIZER_MACROS_SVH

// Same-cycle implication.
`define ARPN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ARPN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/arpn_pkg.sv @@
package arpn_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int CHAN_W = 2;
   localparam int SAMPLE_W = 16;
   localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int DIV_STEPS = SAMPLE_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [SAMPLE_W-1:0] RESET_LOW = 16'd500;
   localparam logic [SAMPLE_W-1:0] RESET_HIGH = 16'd26000;
   localparam logic [SAMPLE_W-1:0] RESET_MARGIN = 16'd50;
   localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'hFFFF;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [SAMPLE_W-1:0] sample;
   } req_word_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_channel;
      logic [SAMPLE_W-1:0] level;
   } rsp_word_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] low;
      logic [SAMPLE_W-1:0] high;
   } bound_pair_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_LOAD    = 4'b0010,
      ST_DIVIDE  = 4'b0100,
      ST_DELIVER = 4'b1000
   } state_type;

endpackage

@@ sv/arpn_divider.sv @@
module arpn_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [arpn_pkg::SAMPLE_W-1:0]   numerator,
   input  logic [arpn_pkg::SAMPLE_W-1:0]   denominator,
   output arpn_pkg::div_status_type        status,
   output logic [arpn_pkg::SAMPLE_W-1:0]   quotient
);
   import arpn_pkg::*;

   // Computes numerator * FULL_SCALE / denominator for 0 < numerator < denominator.
   // The upper half of the dividend is numerator - 1, which is already below the
   // denominator, so only the lower half is shifted through the restoring steps.

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic [SAMPLE_W-1:0]   rem_ff, rem_in;
   logic [SAMPLE_W-1:0]   acc_ff, acc_in;
   logic [SAMPLE_W-1:0]   den_ff, den_in;
   logic [SAMPLE_W:0]     shifted;
   logic [SAMPLE_W:0]     diff;
   logic                  fits;

   always_comb begin
      shifted = {rem_ff, acc_ff[SAMPLE_W-1]};
      diff = shifted - {1'b0, den_ff};
      fits = shifted >= {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      count_in = count_ff;
      rem_in = rem_ff;
      acc_in = acc_ff;
      den_in = den_ff;

      if (start) begin
         busy_in = 1'b1;
         count_in = DIV_CNT_W'(DIV_STEPS);
         rem_in = numerator - SAMPLE_W'(1);
         acc_in = ~numerator + SAMPLE_W'(1);
         den_in = denominator;
      end else if (busy_ff) begin
         rem_in = fits ? diff[SAMPLE_W-1:0] : shifted[SAMPLE_W-1:0];
         acc_in = {acc_ff[SAMPLE_W-2:0], fits};
         count_in = count_ff - DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      den_ff <= den_in;
   end

   assign status = '{busy: busy_ff, done: done_ff};
   assign quotient = acc_ff;

endmodule

@@ sv/auto_range_pedal_normalizer.sv @@
// Pedal normaliser: each word carries a channel and a 16-bit sample; the block widens that
// channel's low and high bounds by the margin register and returns the sample's position
// between them as a Q0.16 level, 65535 at the low bound and 0 at the high bound. One word
// is handled at a time, in order: the channel's bounds are read from the state memory, then
// updated and written back, then sixteen steps of the restoring divider run, then the
// quotient is collected and moved into the output register. Words whose level is fixed
// (equal bounds, sample at or beyond a bound) skip the divider. The output register lets
// the next word enter while a result still waits. The bounds live in a small memory with a
// valid bit per channel, so reset takes effect at once with no clearing pass.
`include "auto_range_pedal_normalizer_macros.svh"

module auto_range_pedal_normalizer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  arpn_pkg::req_word_type         req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output arpn_pkg::rsp_word_type         rsp_word,
   input  logic                           csr_write_enable,
   input  logic [arpn_pkg::SAMPLE_W-1:0]  csr_write_data
);
   import arpn_pkg::*;

   state_type              state_ff, state_in;
   logic [SAMPLE_W-1:0]    margin_ff;
   req_word_type           item_ff;
   logic [NUM_CHANNELS-1:0] valid_ff;
   bound_pair_type         bound_mem [NUM_CHANNELS];
   bound_pair_type         rd_data_ff;
   logic                   rd_valid_ff;
   logic [SAMPLE_W-1:0]    res_level_ff, res_level_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff;

   logic                   accept;
   logic                   deliver_fire;
   logic [ADDR_W-1:0]      rd_addr;
   logic [ADDR_W-1:0]      wr_addr;
   logic                   chan_ok;
   bound_pair_type         cur;
   logic [SAMPLE_W:0]      up;
   logic [SAMPLE_W-1:0]    down;
   logic [SAMPLE_W-1:0]    lo_new;
   logic [SAMPLE_W-1:0]    hi_new;
   logic                   ordered;
   logic [SAMPLE_W-1:0]    num;
   logic [SAMPLE_W-1:0]    den;
   logic                   num_pos;
   logic [SAMPLE_W-1:0]    fixed_level;
   logic                   mem_we;
   logic                   div_start;
   div_status_type         div_status;
   logic [SAMPLE_W-1:0]    div_quotient;

   assign req_stall = !(state_ff == ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign deliver_fire = (state_ff == ST_DELIVER) && (!rsp_valid_ff || !rsp_stall);

   assign rd_addr = req_word.channel[ADDR_W-1:0];
   assign wr_addr = item_ff.channel[ADDR_W-1:0];
   assign chan_ok = 32'(item_ff.channel) < NUM_CHANNELS;

   always_comb begin
      cur = rd_valid_ff ? rd_data_ff : bound_pair_type'{low: RESET_LOW, high: RESET_HIGH};
      up = {1'b0, item_ff.sample} + {1'b0, margin_ff};
      down = (item_ff.sample > margin_ff) ? item_ff.sample - margin_ff : '0;
      lo_new = (up < {1'b0, cur.low}) ? up[SAMPLE_W-1:0] : cur.low;
      hi_new = (down > cur.high) ? down : cur.high;

      ordered = hi_new >= lo_new;
      if (ordered) begin
         den = hi_new - lo_new;
         num = hi_new - item_ff.sample;
         num_pos = item_ff.sample < hi_new;
      end else begin
         den = lo_new - hi_new;
         num = item_ff.sample - hi_new;
         num_pos = item_ff.sample > hi_new;
      end

      if (!chan_ok || den == '0 || !num_pos) begin
         fixed_level = '0;
      end else begin
         fixed_level = FULL_SCALE;
      end
   end

   assign mem_we = (state_ff == ST_LOAD) && chan_ok;
   assign div_start = mem_we && (den != '0) && num_pos && (num < den);

   arpn_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (num),
      .denominator (den),
      .status      (div_status),
      .quotient    (div_quotient)
   );

   always_comb begin
      state_in = state_ff;
      res_level_in = res_level_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            res_level_in = fixed_level;
            state_in = div_start ? ST_DIVIDE : ST_DELIVER;
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               res_level_in = div_quotient;
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (deliver_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = deliver_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         margin_ff <= RESET_MARGIN;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            margin_ff <= csr_write_data;
         end
         if (mem_we) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bound_mem[wr_addr] <= bound_pair_type'{low: lo_new, high: hi_new};
      end
      if (accept) begin
         rd_data_ff <= bound_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         item_ff <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      res_level_ff <= res_level_in;
      if (deliver_fire) begin
         rsp_word_ff <= rsp_word_type'{out_channel: item_ff.channel, level: res_level_ff};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   `ARPN_ASSERT_NEXT(a_accept_to_load, clock, reset, accept, state_ff == ST_LOAD, "load missed")
   `ARPN_ASSERT_IMP(a_bounds_ordered, clock, reset, mem_we, lo_new <= hi_new, "bounds reversed")
   `ARPN_ASSERT_IMP(a_div_done, clock, reset, div_status.done, state_ff == ST_DIVIDE, "bad done")
   `ARPN_ASSERT_NEXT(a_rsp_from_deliver, clock, reset, deliver_fire, rsp_valid_ff, "result lost")

endmodule

@@ tb/tb_auto_range_pedal_normalizer.sv @@
`timescale 1ns / 1ps

module tb_auto_range_pedal_normalizer;
   import arpn_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [SAMPLE_W-1:0] sample;
      logic level_known;
      logic [SAMPLE_W-1:0] level;
   } probe_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_write_enable = 1'b0;
   logic [SAMPLE_W-1:0] csr_write_data = '0;

   logic [SAMPLE_W-1:0] margin_model = RESET_MARGIN;
   logic [SAMPLE_W-1:0] low_track [NUM_CHANNELS];
   logic [SAMPLE_W-1:0] high_track [NUM_CHANNELS];
   rsp_word_type pending_levels [$];
   int mismatch_count = 0;
   int stall_left = 0;
   bit quiet = 1'b0;
   logic [SAMPLE_W-1:0] phase_margins [7];

   probe_row_type probe_table [15] = '{
      '{2'd0, 16'd26000, 1'b1, 16'd0},
      '{2'd0, 16'd25999, 1'b0, 16'd0},
      '{2'd0, 16'd500,   1'b1, 16'd65535},
      '{2'd0, 16'd501,   1'b0, 16'd0},
      '{2'd1, 16'd0,     1'b1, 16'd65535},
      '{2'd1, 16'd65535, 1'b1, 16'd0},
      '{2'd2, 16'd13250, 1'b0, 16'd0},
      '{2'd2, 16'd40000, 1'b1, 16'd0},
      '{2'd3, 16'd1,     1'b1, 16'd65535},
      '{2'd3, 16'h8000,  1'b1, 16'd0},
      '{2'd3, 16'h5555,  1'b0, 16'd0},
      '{2'd2, 16'hAAAA,  1'b0, 16'd0},
      '{2'd1, 16'd32767, 1'b0, 16'd0},
      '{2'd0, 16'hFFFF,  1'b1, 16'd0},
      '{2'd1, 16'h00FF,  1'b0, 16'd0}
   };

   auto_range_pedal_normalizer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic logic [SAMPLE_W-1:0] scale_level(logic [SAMPLE_W-1:0] lo,
                                                       logic [SAMPLE_W-1:0] hi,
                                                       logic [SAMPLE_W-1:0] s);
      longint num;
      longint den;
      longint quot;
      num = longint'(hi) - longint'(s);
      den = longint'(hi) - longint'(lo);
      if (den == 0) return '0;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      if (num <= 0) return '0;
      if (num >= den) return FULL_SCALE;
      quot = (num * 65535) / den;
      return quot[SAMPLE_W-1:0];
   endfunction

   function automatic rsp_word_type track_and_scale(req_word_type w);
      logic [SAMPLE_W:0] up;
      logic [SAMPLE_W-1:0] down;
      logic [SAMPLE_W-1:0] lo;
      logic [SAMPLE_W-1:0] hi;
      rsp_word_type r;
      r.out_channel = w.channel;
      r.level = '0;
      if (w.channel < NUM_CHANNELS) begin
         up = {1'b0, w.sample} + {1'b0, margin_model};
         down = (w.sample > margin_model) ? w.sample - margin_model : '0;
         lo = low_track[w.channel];
         hi = high_track[w.channel];
         if (up < {1'b0, lo}) lo = up[SAMPLE_W-1:0];
         if (down > hi) hi = down;
         low_track[w.channel] = lo;
         high_track[w.channel] = hi;
         r.level = scale_level(lo, hi, w.sample);
      end
      return r;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample(int ch);
      int lo;
      int hi;
      int v;
      int mode;
      lo = int'(low_track[ch]);
      hi = int'(high_track[ch]);
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
         v = $urandom_range(hi, lo);
      end else if (mode <= 7) begin
         v = ($urandom_range(0, 1) ? lo : hi) + $urandom_range(0, 100) - 50;
         if (v < 0) v = 0;
         if (v > 65535) v = 65535;
      end else begin
         v = $urandom_range(0, 65535);
      end
      return v[SAMPLE_W-1:0];
   endfunction

   task automatic send_word(input req_word_type w, input logic level_known,
                            input logic [SAMPLE_W-1:0] known_level);
      int gap;
      rsp_word_type want;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_word = w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = track_and_scale(w);
      if (level_known) want.level = known_level;
      pending_levels.push_back(want);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      req_word_type w;
      for (int i = 0; i < count; i++) begin
         w.channel = CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
         w.sample = pick_sample(int'(w.channel));
         send_word(w, 1'b0, '0);
      end
   endtask

   task automatic drain;
      req_valid = 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_margin(input logic [SAMPLE_W-1:0] value);
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      margin_model = value;
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_levels.size() == 0) begin
            $error("unexpected result word: out_channel %0d level %0d",
                   rsp_word.out_channel, rsp_word.level);
            mismatch_count++;
         end else begin
            want = pending_levels.pop_front();
            if (rsp_word.out_channel !== want.out_channel) begin
               $error("out_channel: expected %0d, actual %0d",
                      want.out_channel, rsp_word.out_channel);
               mismatch_count++;
            end
            if (rsp_word.level !== want.level) begin
               $error("level: expected %0d, actual %0d", want.level, rsp_word.level);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      req_word_type w;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         low_track[c] = RESET_LOW;
         high_track[c] = RESET_HIGH;
      end
      phase_margins[0] = 16'hFFFF;
      phase_margins[1] = 16'd0;
      phase_margins[2] = 16'd1;
      phase_margins[3] = 16'h8000;
      phase_margins[4] = SAMPLE_W'($urandom_range(2, 65534));
      phase_margins[5] = SAMPLE_W'($urandom_range(2, 65534));
      phase_margins[6] = RESET_MARGIN;

      repeat (8) @(negedge clock);
      reset = 1'b0;

      foreach (probe_table[i]) begin
         w.channel = probe_table[i].channel;
         w.sample = probe_table[i].sample;
         send_word(w, probe_table[i].level_known, probe_table[i].level);
      end
      send_random(150);

      for (int p = 0; p < 7; p++) begin
         drain();
         write_margin(phase_margins[p]);
         // The final phase runs with both sides always ready.
         if (p == 6) quiet = 1'b1;
         send_random(150);
      end

      drain();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ auto_range_pedal_normalizer.f @@
+incdir+sv
sv/arpn_pkg.sv
sv/arpn_divider.sv
sv/auto_range_pedal_normalizer.sv
tb/tb_auto_range_pedal_normalizer.sv
